// ----- src/damped_spring_force_defines.svh -----
// Assertion macros shared by the spring force block.
// Each expects clk and rst in scope at the point of use.
`ifndef DAMPED_SPRING_FORCE_DEFINES_SVH
`define DAMPED_SPRING_FORCE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define DSF_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spring force check failed");

// Consequent must hold in the cycle after the antecedent
`define DSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spring force check failed");

`endif

// ----- src/dsf_pkg.sv -----
package dsf_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  // fraction bits of the unit vector
  localparam int UNIT_BITS       = 30;
  localparam int AXES            = 3;
  localparam int REG_IDX_W       = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_STIFFNESS   = 2'd0,
    REG_REST_LENGTH = 2'd1,
    REG_DAMPING     = 2'd2
  } dsf_reg_t;

endpackage

// ----- src/dsf_mul.sv -----
module dsf_mul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int LO = WA / 2;
  localparam int HI = WA - LO;

  logic signed [LO+WB:0]   pl;
  logic signed [HI+WB-1:0] ph;

  // Split a into halves, register partial products, then combine
  always_ff @(posedge clk) begin
    if (en) begin
      pl <= $signed({1'b0, a[LO-1:0]}) * b;
      ph <= $signed(a[WA-1:LO]) * b;
      p  <= $signed({ph, {LO{1'b0}}}) + (WA+WB)'(pl);
    end
  end

endmodule

// ----- src/dsf_sqrt_cell.sv -----
module dsf_sqrt_cell #(
  parameter int RADW  = 66,
  parameter int ROOTW = 33,
  parameter int PW    = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vld_in,
  input  logic [RADW-1:0]    rad_in,
  input  logic [ROOTW+2:0]   rem_in,
  input  logic [ROOTW-1:0]   root_in,
  input  logic [PW-1:0]      pass_in,
  output logic               vld_out,
  output logic [RADW-1:0]    rad_out,
  output logic [ROOTW+2:0]   rem_out,
  output logic [ROOTW-1:0]   root_out,
  output logic [PW-1:0]      pass_out
);

  localparam int RMW = ROOTW + 3;

  logic [RMW-1:0] rem_sh;
  logic [RMW-1:0] trial;
  logic           take;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {rem_in[RMW-3:0], rad_in[RADW-1 -: 2]};
    trial  = {1'b0, root_in, 2'b01};
    take   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  // Advance the partial root and carry the passenger data
  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= rad_in << 2;
      rem_out  <= take ? rem_sh - trial : rem_sh;
      root_out <= {root_in[ROOTW-2:0], take};
      pass_out <= pass_in;
    end
  end

endmodule

// ----- src/dsf_div_cell.sv -----
module dsf_div_cell
  import dsf_pkg::*;
#(
  parameter int DENW = 33,
  parameter int QW   = 31,
  parameter int PW   = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             vld_in,
  input  logic [DENW-1:0]                  den_in,
  input  logic [AXES-1:0][DENW:0]          rem_in,
  input  logic [AXES-1:0][QW-1:0]          quo_in,
  input  logic [PW-1:0]                    pass_in,
  output logic                             vld_out,
  output logic [DENW-1:0]                  den_out,
  output logic [AXES-1:0][DENW:0]          rem_out,
  output logic [AXES-1:0][QW-1:0]          quo_out,
  output logic [PW-1:0]                    pass_out
);

  localparam int RW = DENW + 1;

  logic [AXES-1:0]         ge;
  logic [AXES-1:0][RW-1:0] diff;

  // One restoring step per lane, all lanes sharing the divisor
  always_comb begin
    for (int j = 0; j < AXES; j++) begin
      ge[j]   = rem_in[j] >= {1'b0, den_in};
      diff[j] = ge[j] ? rem_in[j] - {1'b0, den_in} : rem_in[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  // Shift the remainder up and append the quotient bit
  always_ff @(posedge clk) begin
    if (en) begin
      den_out  <= den_in;
      pass_out <= pass_in;
      for (int j = 0; j < AXES; j++) begin
        rem_out[j] <= {diff[j][RW-2:0], 1'b0};
        quo_out[j] <= {quo_in[j][QW-2:0], ge[j]};
      end
    end
  end

endmodule

// ----- src/damped_spring_force.sv -----
// Pipeline: VALUE_WIDTH+1 square root cells and 31 divider cells make up most of the
// registers between input transfer and result.
// Throughput: one spring per cycle; the whole pipeline holds while a result
// waits on a stalled output.
// Reset: clears all valid bits and loads stiffness 1.0, rest length 1.0, damping 0.
`include "damped_spring_force_defines.svh"

module damped_spring_force
  import dsf_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [REG_IDX_W-1:0]          cfg_index,
  input  logic [VALUE_WIDTH-1:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] a_pos_x,
  input  logic signed [VALUE_WIDTH-1:0] a_pos_y,
  input  logic signed [VALUE_WIDTH-1:0] a_pos_z,
  input  logic signed [VALUE_WIDTH-1:0] b_pos_x,
  input  logic signed [VALUE_WIDTH-1:0] b_pos_y,
  input  logic signed [VALUE_WIDTH-1:0] b_pos_z,
  input  logic signed [VALUE_WIDTH-1:0] a_vel_x,
  input  logic signed [VALUE_WIDTH-1:0] a_vel_y,
  input  logic signed [VALUE_WIDTH-1:0] a_vel_z,
  input  logic signed [VALUE_WIDTH-1:0] b_vel_x,
  input  logic signed [VALUE_WIDTH-1:0] b_vel_y,
  input  logic signed [VALUE_WIDTH-1:0] b_vel_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] grad_x,
  output logic signed [VALUE_WIDTH-1:0] grad_y,
  output logic signed [VALUE_WIDTH-1:0] grad_z,
  output logic [VALUE_WIDTH-1:0]        energy,
  output logic                          zero_length
);

  localparam int W     = VALUE_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int DW    = W + 1;
  localparam int SUMW  = 2 * DW;
  localparam int LW    = DW;
  localparam int RMW   = LW + 3;
  localparam int RW    = LW + 1;
  localparam int QW    = UNIT_BITS + 1;
  localparam int NW    = UNIT_BITS + 2;
  localparam int SW    = LW + 2;
  localparam int KW    = W + 1;
  localparam int ACW   = NW + DW + 2;
  localparam int DOTW  = ACW - UNIT_BITS;
  localparam int KSW   = KW + SW - F;
  localparam int S2W   = 2 * SW - F;
  localparam int BDW   = KW + DOTW - F;
  localparam int CW    = BDW + 1;
  localparam int EW    = S2W + KW - F - 1;
  localparam int GW    = CW + NW - UNIT_BITS;
  localparam int SQPW  = 2 * AXES * DW;
  localparam int DVPW  = SW + AXES * DW + AXES + 1;
  localparam logic [W-1:0]  ONE      = W'(1) << F;
  localparam logic [QW-1:0] UNIT_ONE = QW'(1) << UNIT_BITS;

  logic [W-1:0]   stiffness;
  logic [W-2:0]   rest_length;
  logic [W-1:0]   damping;
  logic [KW-1:0]  k_s;
  logic [KW-1:0]  b_s;
  logic           adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness   <= ONE;
      rest_length <= ONE[W-2:0];
      damping     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STIFFNESS:   stiffness   <= cfg_data;
        REG_REST_LENGTH: rest_length <= cfg_data[W-2:0];
        REG_DAMPING:     damping     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign k_s = {1'b0, stiffness};
  assign b_s = {1'b0, damping};

  // Whole pipeline advances unless a result is held at the output
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // ---------------- differences ----------------
  logic signed [W-1:0] pa [AXES];
  logic signed [W-1:0] pb [AXES];
  logic signed [W-1:0] va [AXES];
  logic signed [W-1:0] vb [AXES];

  assign pa[0] = a_pos_x;  assign pa[1] = a_pos_y;  assign pa[2] = a_pos_z;
  assign pb[0] = b_pos_x;  assign pb[1] = b_pos_y;  assign pb[2] = b_pos_z;
  assign va[0] = a_vel_x;  assign va[1] = a_vel_y;  assign va[2] = a_vel_z;
  assign vb[0] = b_vel_x;  assign vb[1] = b_vel_y;  assign vb[2] = b_vel_z;

  logic                      s1_vld;
  logic [AXES-1:0][DW-1:0]   s1_d;
  logic [AXES-1:0][DW-1:0]   s1_dv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < AXES; j++) begin
        s1_d[j]  <= DW'(pb[j]) - DW'(pa[j]);
        s1_dv[j] <= DW'(vb[j]) - DW'(va[j]);
      end
    end
  end

  // ---------------- squares ----------------
  logic [AXES-1:0][SUMW-1:0] sq_p;
  logic                      sq_vld [2];
  logic [AXES-1:0][DW-1:0]   sq_d   [2];
  logic [AXES-1:0][DW-1:0]   sq_dv  [2];

  for (genvar j = 0; j < AXES; j++) begin : g_sq
    dsf_mul #(.WA(DW), .WB(DW)) u_sq (
      .clk (clk),
      .en  (adv),
      .a   (s1_d[j]),
      .b   (s1_d[j]),
      .p   (sq_p[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
      sq_vld[1] <= 1'b0;
    end else if (adv) begin
      sq_vld[0] <= s1_vld;
      sq_vld[1] <= sq_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_d[0]  <= s1_d;
      sq_d[1]  <= sq_d[0];
      sq_dv[0] <= s1_dv;
      sq_dv[1] <= sq_dv[0];
    end
  end

  // Sum of squares
  logic            sum_vld;
  logic [SUMW-1:0] sum_rad;
  logic [SQPW-1:0] sum_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld <= 1'b0;
    end else if (adv) begin
      sum_vld <= sq_vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_rad  <= sq_p[0] + sq_p[1] + sq_p[2];
      sum_pass <= {sq_d[1], sq_dv[1]};
    end
  end

  // ---------------- square root chain ----------------
  logic [LW:0]             qc_vld;
  logic [LW:0][SUMW-1:0]   qc_rad;
  logic [LW:0][RMW-1:0]    qc_rem;
  logic [LW:0][LW-1:0]     qc_root;
  logic [LW:0][SQPW-1:0]   qc_pass;

  assign qc_vld[0]  = sum_vld;
  assign qc_rad[0]  = sum_rad;
  assign qc_rem[0]  = '0;
  assign qc_root[0] = '0;
  assign qc_pass[0] = sum_pass;

  for (genvar i = 0; i < LW; i++) begin : g_sqrt
    dsf_sqrt_cell #(.RADW(SUMW), .ROOTW(LW), .PW(SQPW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .vld_in   (qc_vld[i]),
      .rad_in   (qc_rad[i]),
      .rem_in   (qc_rem[i]),
      .root_in  (qc_root[i]),
      .pass_in  (qc_pass[i]),
      .vld_out  (qc_vld[i+1]),
      .rad_out  (qc_rad[i+1]),
      .rem_out  (qc_rem[i+1]),
      .root_out (qc_root[i+1]),
      .pass_out (qc_pass[i+1])
    );
  end

  logic [AXES-1:0][DW-1:0] r_d;
  logic [AXES-1:0][DW-1:0] r_dv;

  assign {r_d, r_dv} = qc_pass[LW];

  // Length offset, magnitudes and signs for the divider
  logic                    a_vld;
  logic [LW-1:0]           a_l;
  logic [SW-1:0]           a_s;
  logic [AXES-1:0][DW-1:0] a_mag;
  logic [AXES-1:0]         a_sgn;
  logic [AXES-1:0][DW-1:0] a_dv;
  logic                    a_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= qc_vld[LW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_l    <= qc_root[LW];
      a_s    <= SW'(qc_root[LW]) - SW'(rest_length);
      a_dv   <= r_dv;
      a_zero <= qc_root[LW] == '0;
      for (int j = 0; j < AXES; j++) begin
        a_mag[j] <= r_d[j][DW-1] ? (~r_d[j] + 1'b1) : r_d[j];
        a_sgn[j] <= r_d[j][DW-1];
      end
    end
  end

  // ---------------- divider chain ----------------
  logic [QW:0]                      dc_vld;
  logic [QW:0][LW-1:0]              dc_den;
  logic [QW:0][AXES-1:0][RW-1:0]    dc_rem;
  logic [QW:0][AXES-1:0][QW-1:0]    dc_quo;
  logic [QW:0][DVPW-1:0]            dc_pass;

  assign dc_vld[0]  = a_vld;
  assign dc_den[0]  = a_l;
  assign dc_quo[0]  = '0;
  assign dc_pass[0] = {a_s, a_dv, a_sgn, a_zero};

  for (genvar j = 0; j < AXES; j++) begin : g_rem0
    assign dc_rem[0][j] = {1'b0, a_mag[j]};
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    dsf_div_cell #(.DENW(LW), .QW(QW), .PW(DVPW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .vld_in   (dc_vld[i]),
      .den_in   (dc_den[i]),
      .rem_in   (dc_rem[i]),
      .quo_in   (dc_quo[i]),
      .pass_in  (dc_pass[i]),
      .vld_out  (dc_vld[i+1]),
      .den_out  (dc_den[i+1]),
      .rem_out  (dc_rem[i+1]),
      .quo_out  (dc_quo[i+1]),
      .pass_out (dc_pass[i+1])
    );
  end

  logic [SW-1:0]           v_s;
  logic [AXES-1:0][DW-1:0] v_dv;
  logic [AXES-1:0]         v_sgn;
  logic                    v_zero;
  logic [AXES-1:0][QW-1:0] dq;

  assign {v_s, v_dv, v_sgn, v_zero} = dc_pass[QW];
  assign dq = dc_quo[QW];

  // Signed unit vector
  logic                    n_vld;
  logic [AXES-1:0][NW-1:0] n_n;
  logic [AXES-1:0][DW-1:0] n_dv;
  logic [SW-1:0]           n_s;
  logic                    n_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_vld <= 1'b0;
    end else if (adv) begin
      n_vld <= dc_vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_dv   <= v_dv;
      n_s    <= v_s;
      n_zero <= v_zero;
      for (int j = 0; j < AXES; j++) begin
        n_n[j] <= v_sgn[j] ? NW'(0) - NW'(dq[j]) : NW'(dq[j]);
      end
    end
  end

  // ---------------- first products ----------------
  logic [AXES-1:0][NW+DW-1:0] pm_p;
  logic [KW+SW-1:0]           ks_p;
  logic [2*SW-1:0]            ss_p;
  logic                       m1_vld  [2];
  logic [AXES-1:0][NW-1:0]    m1_n    [2];
  logic                       m1_zero [2];

  for (genvar j = 0; j < AXES; j++) begin : g_dot
    dsf_mul #(.WA(NW), .WB(DW)) u_dot (
      .clk (clk),
      .en  (adv),
      .a   (n_n[j]),
      .b   (n_dv[j]),
      .p   (pm_p[j])
    );
  end

  dsf_mul #(.WA(KW), .WB(SW)) u_ks (
    .clk (clk),
    .en  (adv),
    .a   (k_s),
    .b   (n_s),
    .p   (ks_p)
  );

  dsf_mul #(.WA(SW), .WB(SW)) u_ss (
    .clk (clk),
    .en  (adv),
    .a   (n_s),
    .b   (n_s),
    .p   (ss_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld[0] <= 1'b0;
      m1_vld[1] <= 1'b0;
    end else if (adv) begin
      m1_vld[0] <= n_vld;
      m1_vld[1] <= m1_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_n[0]    <= n_n;
      m1_n[1]    <= m1_n[0];
      m1_zero[0] <= n_zero;
      m1_zero[1] <= m1_zero[0];
    end
  end

  // Dot product, scaled spring term and squared offset
  logic [ACW-1:0]          b_acc;
  logic                    b_vld;
  logic [DOTW-1:0]         b_dot;
  logic [KSW-1:0]          b_kst;
  logic [S2W-1:0]          b_s2;
  logic [AXES-1:0][NW-1:0] b_n;
  logic                    b_zero;

  assign b_acc = ACW'($signed(pm_p[0])) + ACW'($signed(pm_p[1]))
               + ACW'($signed(pm_p[2]));

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= m1_vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_dot  <= b_acc[ACW-1:UNIT_BITS];
      b_kst  <= ks_p[KW+SW-1:F];
      b_s2   <= ss_p[2*SW-1:F];
      b_n    <= m1_n[1];
      b_zero <= m1_zero[1];
    end
  end

  // ---------------- second products ----------------
  logic [KW+DOTW-1:0]      bd_p;
  logic [S2W+KW-1:0]       ke_p;
  logic                    m2_vld  [2];
  logic [KSW-1:0]          m2_kst  [2];
  logic [AXES-1:0][NW-1:0] m2_n    [2];
  logic                    m2_zero [2];

  dsf_mul #(.WA(KW), .WB(DOTW)) u_bd (
    .clk (clk),
    .en  (adv),
    .a   (b_s),
    .b   (b_dot),
    .p   (bd_p)
  );

  dsf_mul #(.WA(S2W), .WB(KW)) u_ke (
    .clk (clk),
    .en  (adv),
    .a   (b_s2),
    .b   (k_s),
    .p   (ke_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_vld[0] <= 1'b0;
      m2_vld[1] <= 1'b0;
    end else if (adv) begin
      m2_vld[0] <= b_vld;
      m2_vld[1] <= m2_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_kst[0]  <= b_kst;
      m2_kst[1]  <= m2_kst[0];
      m2_n[0]    <= b_n;
      m2_n[1]    <= m2_n[0];
      m2_zero[0] <= b_zero;
      m2_zero[1] <= m2_zero[0];
    end
  end

  // Force coefficient and saturated energy
  logic [CW-1:0]           c_sum;
  logic [EW-1:0]           e_full;
  logic [W-1:0]            e_sat;
  logic                    c_vld;
  logic [CW-1:0]           c_c;
  logic [W-1:0]            c_en;
  logic [AXES-1:0][NW-1:0] c_n;
  logic                    c_zero;

  always_comb begin
    c_sum  = CW'($signed(m2_kst[1])) + CW'($signed(bd_p[KW+DOTW-1:F]));
    e_full = ke_p[S2W+KW-1:F+1];
    e_sat  = (|e_full[EW-1:W]) ? '1 : e_full[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (adv) begin
      c_vld <= m2_vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_c    <= c_sum;
      c_en   <= e_sat;
      c_n    <= m2_n[1];
      c_zero <= m2_zero[1];
    end
  end

  // ---------------- gradient products ----------------
  logic [AXES-1:0][CW+NW-1:0] gm_p;
  logic                       m3_vld  [2];
  logic [W-1:0]               m3_en   [2];
  logic                       m3_zero [2];

  for (genvar j = 0; j < AXES; j++) begin : g_grad
    dsf_mul #(.WA(CW), .WB(NW)) u_grad (
      .clk (clk),
      .en  (adv),
      .a   (c_c),
      .b   (c_n[j]),
      .p   (gm_p[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_vld[0] <= 1'b0;
      m3_vld[1] <= 1'b0;
    end else if (adv) begin
      m3_vld[0] <= c_vld;
      m3_vld[1] <= m3_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_en[0]   <= c_en;
      m3_en[1]   <= m3_en[0];
      m3_zero[0] <= c_zero;
      m3_zero[1] <= m3_zero[0];
    end
  end

  // Saturate each gradient component to the signed output range
  logic [AXES-1:0][GW-1:0] gf;
  logic [AXES-1:0][W-1:0]  g_sat;

  always_comb begin
    for (int j = 0; j < AXES; j++) begin
      gf[j] = gm_p[j][CW+NW-1:UNIT_BITS];
      if (gf[j][GW-1:W-1] == '0 || gf[j][GW-1:W-1] == '1) begin
        g_sat[j] = gf[j][W-1:0];
      end else begin
        g_sat[j] = gf[j][GW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= m3_vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grad_x      <= m3_zero[1] ? '0 : g_sat[0];
      grad_y      <= m3_zero[1] ? '0 : g_sat[1];
      grad_z      <= m3_zero[1] ? '0 : g_sat[2];
      energy      <= m3_en[1];
      zero_length <= m3_zero[1];
    end
  end

  // ---------------- checks ----------------
  `DSF_ASSERT_IMPLIES(a_zero_grad, out_valid && zero_length, grad_x == '0 && grad_y == '0 && grad_z == '0)
  `DSF_ASSERT_IMPLIES(a_root_zero, qc_vld[LW] && qc_root[LW] == '0, r_d == '0)
  `DSF_ASSERT_IMPLIES(a_unit_bound, dc_vld[QW] && !v_zero, dq[0] <= UNIT_ONE && dq[1] <= UNIT_ONE && dq[2] <= UNIT_ONE)
  `DSF_ASSERT_NEXT(a_zero_track, adv && m3_vld[1] && m3_zero[1], zero_length && energy == $past(m3_en[1]))

endmodule
